/* rtl/imht_pkg.sv */
// Shared types, constants and codes for the indexed min-heap timer unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package imht_pkg;

  localparam int HEAP_CAPACITY = 64;
  localparam int HEAP_AW = $clog2(HEAP_CAPACITY);
  localparam int CNT_W = HEAP_AW + 1;
  localparam int KEY_SPACE = 1024;
  localparam int KEY_W = 10;
  localparam int DL_W = 48;
  localparam int TMO_W = 31;
  localparam int ELP_W = 16;
  localparam int MAX_EXPIRE_PER_ITEM = 63;
  localparam int EXP_W = 6;
  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_ADJUST  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_FULL    = 2'd1,
    ERR_UNKNOWN = 2'd2,
    ERR_RSVD    = 2'd3
  } err_t;

  localparam logic signed [31:0] REM_EMPTY = -32'sd1;
  localparam logic [31:0] REM_SAT = 32'h7FFF_FFFF;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [TMO_W-1:0] timeout;
    logic [ELP_W-1:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DL_W-1:0]  dl;
  } heap_ent_t;

endpackage
`default_nettype wire

/* rtl/imht_front.sv */
// Front end: accepts input words, decodes the operation and queues commands.
// Depends on imht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imht_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [1:0]            operation,
  input  wire logic [9:0]            key,
  input  wire logic [30:0]           timeout_ms,
  input  wire logic [15:0]           elapsed_ms,
  output      logic                  cmd_valid,
  input  wire logic                  cmd_ready,
  output      imht_pkg::cmd_t        cmd
);
  import imht_pkg::*;

  cmd_t q [CMDQ_DEPTH];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;
  cmd_t in_cmd;
  logic push;
  logic pop;

  always_comb begin
    in_cmd.op      = op_t'(operation);
    // key space matches the key width, so the reduced key is the key itself
    in_cmd.key     = key;
    in_cmd.timeout = timeout_ms;
    in_cmd.elapsed = elapsed_ms;
  end

  assign in_ready  = (fill != 2'(CMDQ_DEPTH));
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/imht_back.sv */
// Back end: heap and key map memories, sift sequencer and result register.
// Depends on imht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imht_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output      logic                  cmd_ready,
  input  wire imht_pkg::cmd_t        cmd,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [1:0]            kind,
  output      logic [9:0]            expired_key,
  output      logic signed [31:0]    remaining_ms,
  output      logic [1:0]            error_code,
  output      logic                  last
);
  import imht_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_LOOK1    = 12'b0000_0000_0010,
    S_LOOK2    = 12'b0000_0000_0100,
    S_DN_RD    = 12'b0000_0000_1000,
    S_DN_CMP   = 12'b0000_0001_0000,
    S_UP_RD    = 12'b0000_0010_0000,
    S_UP_CMP   = 12'b0000_0100_0000,
    S_PLACE    = 12'b0000_1000_0000,
    S_ROOT_RD  = 12'b0001_0000_0000,
    S_ROOT_CMP = 12'b0010_0000_0000,
    S_RESP     = 12'b0100_0000_0000,
    S_INIT     = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  // memories
  heap_ent_t        heap_mem [HEAP_CAPACITY];
  logic [HEAP_AW-1:0] slot_mem [KEY_SPACE];
  logic [HEAP_AW-1:0] heap_ra0, heap_ra1, heap_wa;
  heap_ent_t        heap_rd0, heap_rd1, heap_wd;
  logic             heap_we;
  logic [KEY_W-1:0] slot_ra, slot_wa;
  logic [HEAP_AW-1:0] slot_rd, slot_wd;
  logic             slot_we;
  logic [KEY_W-1:0] init_idx;

  cmd_t             cur;
  logic [DL_W-1:0]  now_ms;
  logic [CNT_W-1:0] count;
  logic [HEAP_AW-1:0] pos;
  logic [CNT_W-1:0] lim;
  heap_ent_t        mv;
  logic             moved;
  logic             pop_mode;
  logic [EXP_W-1:0] n_exp;
  kind_t            resp_kind;
  logic [KEY_W-1:0] resp_key;
  logic [31:0]      resp_rem;
  err_t             resp_err;

  logic             out_free;
  logic             out_load;
  kind_t            out_kind_d;
  logic [KEY_W-1:0] out_key_d;
  logic [31:0]      out_rem_d;
  err_t             out_err_d;
  logic             out_last_d;

  logic [CNT_W-1:0] lchild;
  logic [CNT_W:0]   rchild;
  logic             has_left, has_right, take_right;
  heap_ent_t        child;
  logic             present;
  logic             expire;
  logic [DL_W-1:0]  diff;
  logic [31:0]      rem;

  assign out_free = !out_valid || out_ready;

  assign lchild    = {pos, 1'b1};
  assign rchild    = {1'b0, lchild} + (CNT_W+1)'(1);
  assign has_left  = lchild < lim;
  assign has_right = rchild < {1'b0, lim};
  assign take_right = has_right && (heap_rd1.dl < heap_rd0.dl);
  assign child     = take_right ? heap_rd1 : heap_rd0;
  assign present   = ({1'b0, slot_rd} < count) && (heap_rd0.key == cur.key);
  assign expire    = (n_exp < EXP_W'(MAX_EXPIRE_PER_ITEM)) && (heap_rd0.dl <= now_ms);
  assign diff      = heap_rd0.dl - now_ms;

  always_comb begin
    if (heap_rd0.dl <= now_ms) begin
      rem = 32'd0;
    end else if (diff[DL_W-1:31] != '0) begin
      rem = REM_SAT;
    end else begin
      rem = {1'b0, diff[30:0]};
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_rd0 <= heap_mem[heap_ra0];
    heap_rd1 <= heap_mem[heap_ra1];
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    heap_ra0   = '0;
    heap_ra1   = '0;
    heap_we    = 1'b0;
    heap_wa    = pos;
    heap_wd    = mv;
    slot_ra    = cur.key;
    slot_we    = 1'b0;
    slot_wa    = mv.key;
    slot_wd    = pos;
    out_load   = 1'b0;
    out_kind_d = resp_kind;
    out_key_d  = resp_key;
    out_rem_d  = resp_rem;
    out_err_d  = resp_err;
    out_last_d = 1'b1;

    unique case (state)
      S_INIT: begin
        // zero the key map once so every lookup reads a defined slot
        slot_we = 1'b1;
        slot_wa = init_idx;
        slot_wd = '0;
        if (init_idx == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_ready = 1'b1;
        slot_ra   = cmd.key;
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_ADD, OP_ADJUST: state_next = S_LOOK1;
            OP_ADVANCE:        state_next = S_ROOT_RD;
            OP_CLEAR:          state_next = S_RESP;
            default:           state_next = S_IDLE;
          endcase
        end
      end
      S_LOOK1: begin
        heap_ra0   = slot_rd;
        state_next = S_LOOK2;
      end
      S_LOOK2: begin
        if (present) begin
          state_next = S_DN_RD;
        end else if (cur.op == OP_ADJUST || count == CNT_W'(HEAP_CAPACITY)) begin
          state_next = S_RESP;
        end else begin
          state_next = S_UP_RD;
        end
      end
      S_DN_RD: begin
        heap_ra0 = lchild[HEAP_AW-1:0];
        heap_ra1 = rchild[HEAP_AW-1:0];
        if (has_left) begin
          state_next = S_DN_CMP;
        end else if (!pop_mode && !moved) begin
          state_next = S_UP_RD;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_CMP: begin
        if (mv.dl < child.dl) begin
          state_next = (!pop_mode && !moved) ? S_UP_RD : S_PLACE;
        end else begin
          // pull the smaller child up into the hole
          heap_we    = 1'b1;
          heap_wd    = child;
          slot_we    = 1'b1;
          slot_wa    = child.key;
          state_next = S_DN_RD;
        end
      end
      S_UP_RD: begin
        heap_ra0 = (pos - HEAP_AW'(1)) >> 1;
        state_next = (pos == '0) ? S_PLACE : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (heap_rd0.dl < mv.dl) begin
          state_next = S_PLACE;
        end else begin
          heap_we    = 1'b1;
          heap_wd    = heap_rd0;
          slot_we    = 1'b1;
          slot_wa    = heap_rd0.key;
          state_next = S_UP_RD;
        end
      end
      S_PLACE: begin
        heap_we    = 1'b1;
        slot_we    = 1'b1;
        state_next = pop_mode ? S_ROOT_RD : S_RESP;
      end
      S_ROOT_RD: begin
        heap_ra0   = '0;
        heap_ra1   = HEAP_AW'(count - CNT_W'(1));
        state_next = (count == '0) ? S_RESP : S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        heap_ra0 = '0;
        heap_ra1 = HEAP_AW'(count - CNT_W'(1));
        if (expire) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_kind_d = KIND_EXPIRED;
            out_key_d  = heap_rd0.key;
            out_rem_d  = 32'd0;
            out_err_d  = ERR_NONE;
            out_last_d = 1'b0;
            state_next = (count > CNT_W'(1)) ? S_DN_RD : S_ROOT_RD;
          end
        end else begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur       <= cmd;
        resp_kind <= KIND_ACK;
        resp_key  <= cmd.key;
        resp_rem  <= 32'd0;
        resp_err  <= ERR_NONE;
        n_exp     <= '0;
      end
      S_LOOK2: begin
        mv.key   <= cur.key;
        mv.dl    <= now_ms + DL_W'(cur.timeout);
        moved    <= 1'b0;
        pop_mode <= 1'b0;
        lim      <= count;
        if (present) begin
          pos <= slot_rd;
        end else if (cur.op == OP_ADJUST) begin
          resp_kind <= KIND_ERROR;
          resp_err  <= ERR_UNKNOWN;
        end else if (count == CNT_W'(HEAP_CAPACITY)) begin
          resp_kind <= KIND_ERROR;
          resp_err  <= ERR_FULL;
        end else begin
          pos <= HEAP_AW'(count);
        end
      end
      S_DN_CMP: begin
        if (!(mv.dl < child.dl)) begin
          pos   <= take_right ? HEAP_AW'(rchild) : HEAP_AW'(lchild);
          moved <= 1'b1;
        end
      end
      S_UP_CMP: begin
        if (!(heap_rd0.dl < mv.dl)) begin
          pos <= (pos - HEAP_AW'(1)) >> 1;
        end
      end
      S_ROOT_RD: begin
        if (count == '0) begin
          resp_kind <= KIND_REPORT;
          resp_key  <= '0;
          resp_rem  <= REM_EMPTY;
        end
      end
      S_ROOT_CMP: begin
        if (expire) begin
          if (out_free) begin
            // last entry fills the root hole, then sifts down if any entries remain
            n_exp    <= n_exp + EXP_W'(1);
            mv       <= heap_rd1;
            pos      <= '0;
            lim      <= count - CNT_W'(1);
            pop_mode <= 1'b1;
          end
        end else begin
          resp_kind <= KIND_REPORT;
          resp_key  <= '0;
          resp_rem  <= rem;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_idx <= '0;
      count    <= '0;
      now_ms   <= '0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        init_idx <= init_idx + KEY_W'(1);
      end
      if (state == S_IDLE && cmd_valid) begin
        if (cmd.op == OP_CLEAR) begin
          count <= '0;
        end
        if (cmd.op == OP_ADVANCE) begin
          now_ms <= now_ms + DL_W'(cmd.elapsed);
        end
      end
      if (state == S_LOOK2 && !present && cur.op == OP_ADD &&
          count != CNT_W'(HEAP_CAPACITY)) begin
        count <= count + CNT_W'(1);
      end
      if (state == S_ROOT_CMP && expire && out_free) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind         <= out_kind_d;
      expired_key  <= out_key_d;
      remaining_ms <= out_rem_d;
      error_code   <= out_err_d;
      last         <= out_last_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/indexed_min_heap_timer_unit.sv */
// Indexed min-heap timer: add/adjust look the key up, then sift the entry through
// the heap; errors and clear answer without a sift. Advance reports up to 63 expired
// keys, moving the last entry to the root after each, then the next deadline.
// One item is worked at a time; a two-word command queue takes new words meanwhile.
// Reset clears the clock, the entry count, the queue and the result valid flag, then
// a pass zeroes the 1024-entry key-to-slot map before the first command is taken.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_timer_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [9:0]         key,
  input  wire logic [30:0]        timeout_ms,
  input  wire logic [15:0]        elapsed_ms,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         kind,
  output      logic [9:0]         expired_key,
  output      logic signed [31:0] remaining_ms,
  output      logic [1:0]         error_code,
  output      logic               last
);
  import imht_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  imht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .key        (key),
    .timeout_ms (timeout_ms),
    .elapsed_ms (elapsed_ms),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  imht_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .expired_key  (expired_key),
    .remaining_ms (remaining_ms),
    .error_code   (error_code),
    .last         (last)
  );

endmodule
`default_nettype wire

/* rtl/imht_checker.sv */
// Port-level checks for the timer unit, bound to the top level.
// Depends on imht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imht_port_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         kind,
  input wire logic [9:0]         expired_key,
  input wire logic signed [31:0] remaining_ms,
  input wire logic [1:0]         error_code,
  input wire logic               last
);
  import imht_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({kind, expired_key, remaining_ms, error_code, last}))
    else $error("result changed while stalled");

  a_expired_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EXPIRED |-> !last && remaining_ms == 0)
    else $error("expiry word marked last or carries time");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match kind");

  a_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_REPORT |-> last && expired_key == 0 &&
      remaining_ms >= REM_EMPTY)
    else $error("bad deadline report");

endmodule

bind indexed_min_heap_timer_unit imht_port_checker u_imht_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .expired_key  (expired_key),
  .remaining_ms (remaining_ms),
  .error_code   (error_code),
  .last         (last)
);
`default_nettype wire
